// ----- sv/hsa_pkg.sv -----
// Package for the handle slot allocator: widths, command and status codes,
// request/response beat types and the structs passed between the stages.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hsa_pkg;

    localparam int CAPACITY = 1024;
    localparam int HW       = $clog2(CAPACITY);
    localparam int DW       = HW + 1;

    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]    cmd;
        logic [HW-1:0] handle_in;
    } req_t;

    typedef struct packed {
        logic [HW-1:0] handle_out;
        logic [1:0]    status;
        logic [HW-1:0] live_count;
    } rsp_t;

    // Writes made by the commit stage in the current cycle.
    typedef struct packed {
        logic          live_we;
        logic [HW-1:0] live_addr;
        logic          live_val;
        logic          stk_we;
        logic [HW-1:0] stk_addr;
        logic [HW-1:0] stk_data;
        logic [DW-1:0] depth_next;
    } wr_t;

    // Bypass values captured at issue, used in place of stale RAM reads.
    typedef struct packed {
        logic          live_hit;
        logic          live_val;
        logic          top_hit;
        logic [HW-1:0] top_val;
    } fwd_t;

endpackage

`default_nettype wire

// ----- sv/hsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/hsa_issue.sv -----
// Issue stage: input register, RAM read addresses and bypass capture.
// Depends on hsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsa_issue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire hsa_pkg::req_t          req,
    input  wire hsa_pkg::wr_t           wr,
    output      logic                   s2_valid,
    output      hsa_pkg::req_t          s2_req,
    output      hsa_pkg::fwd_t          fwd,
    output      logic [hsa_pkg::HW-1:0] live_raddr,
    output      logic [hsa_pkg::HW-1:0] stk_raddr
);
    import hsa_pkg::*;

    logic          valid_reg;
    req_t          req_reg;
    fwd_t          fwd_reg;
    fwd_t          fwd_next;
    logic [DW-1:0] top_idx;

    // Top of stack as it stands after the commit stage's update this cycle.
    assign top_idx    = wr.depth_next - DW'(1);
    assign stk_raddr  = top_idx[HW-1:0];
    assign live_raddr = req.handle_in;

    always_comb
    begin
        fwd_next.live_hit = wr.live_we && (wr.live_addr == req.handle_in);
        fwd_next.live_val = wr.live_val;
        // A push lands exactly on the slot read as the new top.
        fwd_next.top_hit  = wr.stk_we;
        fwd_next.top_val  = wr.stk_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            req_reg <= req;
            fwd_reg <= fwd_next;
        end
    end

    assign s2_valid = valid_reg;
    assign s2_req   = req_reg;
    assign fwd      = fwd_reg;

endmodule

`default_nettype wire

// ----- sv/hsa_commit.sv -----
// Commit stage: allocator state, decision logic, RAM writes, result register.
// Depends on hsa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsa_commit (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s2_valid,
    input  wire hsa_pkg::req_t          s2_req,
    input  wire hsa_pkg::fwd_t          fwd,
    input  wire logic                   live_rdata,
    input  wire logic [hsa_pkg::HW-1:0] stk_rdata,
    output      hsa_pkg::wr_t           wr,
    output      logic                   done,
    output      hsa_pkg::rsp_t          rsp
);
    import hsa_pkg::*;

    logic [DW-1:0] fresh_reg;
    logic [DW-1:0] fresh_next;
    logic [DW-1:0] depth_reg;
    logic [HW-1:0] total_reg;
    logic [HW-1:0] total_next;
    logic          done_reg;
    rsp_t          rsp_reg;
    rsp_t          rsp_next;
    logic          live_bit;
    logic [HW-1:0] top;
    logic          is_live;
    logic [HW-1:0] h;

    assign h        = s2_req.handle_in;
    assign live_bit = fwd.live_hit ? fwd.live_val : live_rdata;
    assign top      = fwd.top_hit ? fwd.top_val : stk_rdata;
    // Handles at or above the bump pointer were never written: treat as dead.
    assign is_live  = (h != '0) && ({1'b0, h} < fresh_reg) && live_bit;

    always_comb
    begin
        fresh_next          = fresh_reg;
        total_next          = total_reg;
        wr.live_we          = 1'b0;
        wr.live_addr        = h;
        wr.live_val         = 1'b0;
        wr.stk_we           = 1'b0;
        wr.stk_addr         = depth_reg[HW-1:0];
        wr.stk_data         = h;
        wr.depth_next       = depth_reg;
        rsp_next.handle_out = h;
        rsp_next.status     = ST_BAD;
        if (s2_valid)
        begin
            unique case (s2_req.cmd)
                CMD_ALLOC:
                begin
                    priority if (depth_reg != '0)
                    begin
                        wr.depth_next       = depth_reg - DW'(1);
                        wr.live_we          = 1'b1;
                        wr.live_addr        = top;
                        wr.live_val         = 1'b1;
                        total_next          = total_reg + HW'(1);
                        rsp_next.handle_out = top;
                        rsp_next.status     = ST_OK;
                    end
                    else if (fresh_reg < DW'(CAPACITY))
                    begin
                        fresh_next          = fresh_reg + DW'(1);
                        wr.live_we          = 1'b1;
                        wr.live_addr        = fresh_reg[HW-1:0];
                        wr.live_val         = 1'b1;
                        total_next          = total_reg + HW'(1);
                        rsp_next.handle_out = fresh_reg[HW-1:0];
                        rsp_next.status     = ST_OK;
                    end
                    else
                    begin
                        rsp_next.handle_out = '0;
                        rsp_next.status     = ST_FULL;
                    end
                end
                CMD_FREE:
                begin
                    if (is_live && (depth_reg < DW'(CAPACITY)))
                    begin
                        wr.live_we      = 1'b1;
                        wr.stk_we       = 1'b1;
                        wr.depth_next   = depth_reg + DW'(1);
                        total_next      = (total_reg != '0) ? total_reg - HW'(1) : total_reg;
                        rsp_next.status = ST_OK;
                    end
                end
                CMD_LOOKUP:
                begin
                    if (is_live)
                    begin
                        rsp_next.status = ST_OK;
                    end
                end
                default:
                begin
                    rsp_next.status = ST_BAD;
                end
            endcase
        end
        rsp_next.live_count = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg <= DW'(1);
            depth_reg <= '0;
            total_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            fresh_reg <= fresh_next;
            depth_reg <= wr.depth_next;
            total_reg <= total_next;
            done_reg  <= s2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

// ----- sv/handle_slot_allocator.sv -----
// Handle slot allocator: one beat in per cycle, one result per beat.
// The result strobes on done after the issue and done registers.
// Throughput: one beat per cycle; busy is always low. The live-bit and
// free-stack RAMs are read at issue, with bypass from the commit stage.
// Reset: no live handles, empty free stack, bump pointer at handle 1; RAMs
// keep no reset, entries at or above the bump pointer read as not live.
`timescale 1ns / 1ps
`default_nettype none

module handle_slot_allocator (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output      logic          busy,
    input  wire hsa_pkg::req_t req,
    output      logic          done,
    output      hsa_pkg::rsp_t rsp
);
    import hsa_pkg::*;

    wr_t           wr;
    fwd_t          fwd;
    logic          s2_valid;
    req_t          s2_req;
    logic [HW-1:0] live_raddr;
    logic [HW-1:0] stk_raddr;
    logic          live_rdata;
    logic [HW-1:0] stk_rdata;

    assign busy = 1'b0;

    hsa_issue u_issue (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req        (req),
        .wr         (wr),
        .s2_valid   (s2_valid),
        .s2_req     (s2_req),
        .fwd        (fwd),
        .live_raddr (live_raddr),
        .stk_raddr  (stk_raddr)
    );

    hsa_ram #(
        .WIDTH (1),
        .DEPTH (CAPACITY)
    ) u_live_ram (
        .clk   (clk),
        .we    (wr.live_we),
        .waddr (wr.live_addr),
        .wdata (wr.live_val),
        .re    (start),
        .raddr (live_raddr),
        .rdata (live_rdata)
    );

    hsa_ram #(
        .WIDTH (HW),
        .DEPTH (CAPACITY)
    ) u_stack_ram (
        .clk   (clk),
        .we    (wr.stk_we),
        .waddr (wr.stk_addr),
        .wdata (wr.stk_data),
        .re    (start),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    hsa_commit u_commit (
        .clk        (clk),
        .rst_n      (rst_n),
        .s2_valid   (s2_valid),
        .s2_req     (s2_req),
        .fwd        (fwd),
        .live_rdata (live_rdata),
        .stk_rdata  (stk_rdata),
        .wr         (wr),
        .done       (done),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

// ----- sv/hsa_checker.sv -----
// Port-level checks for the handle slot allocator, bound to the top level.
// Depends on hsa_pkg and handle_slot_allocator.
`timescale 1ns / 1ps
`default_nettype none

module hsa_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          busy,
    input  wire hsa_pkg::req_t req,
    input  wire logic          done,
    input  wire hsa_pkg::rsp_t rsp
);
    import hsa_pkg::*;

    logic [1:0] warm_reg;

    // Count cycles since reset so history from before reset is not used.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_reg <= '0;
        end
        else if (warm_reg != 2'd3)
        begin
            warm_reg <= warm_reg + 2'd1;
        end
    end

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (warm_reg >= 2'd2) |-> (done == $past(start && !busy, 2)))
        else $error("result strobe does not follow start by two cycles");

    a_full_null: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == ST_FULL) |-> (rsp.handle_out == '0))
        else $error("full status with nonzero handle");

    a_null_bad: assert property (@(posedge clk) disable iff (!rst_n)
        (done && warm_reg >= 2'd2 && $past(req.handle_in, 2) == '0
            && $past(req.cmd, 2) != CMD_ALLOC) |-> (rsp.status == ST_BAD))
        else $error("null handle accepted");

    a_lookup_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && warm_reg == 2'd3 && $past(done) && $past(req.cmd, 2) == CMD_LOOKUP)
            |-> (rsp.live_count == $past(rsp.live_count)))
        else $error("lookup changed the live count");

endmodule

bind handle_slot_allocator hsa_checker u_hsa_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
);

`default_nettype wire

// ----- test/handle_slot_allocator_test.sv -----
// Self-checking testbench for handle_slot_allocator: directed and random command
// beats, checked against a behavioral model of the allocator.
// Depends on hsa_pkg and the handle_slot_allocator RTL.
`timescale 1ns / 1ps

module handle_slot_allocator_test;

    import hsa_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    req_t  req_bus;
    logic  done;
    rsp_t  rsp_bus;

    handle_slot_allocator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req_bus),
        .done  (done),
        .rsp   (rsp_bus)
    );

    // Allocator model state
    bit            live_map [CAPACITY];
    logic [HW-1:0] free_stk [CAPACITY];
    int            stk_depth = 0;
    int            bump      = 1;
    int            live_cnt  = 0;

    req_t req_q[$];
    rsp_t expected_rsp_q[$];
    int   errors = 0;

    // Driver state
    bit beat_out  = 1'b0;
    int gap_left  = 0;
    bit burst     = 1'b0;
    bit busy_seen = 1'b0;

    function automatic bit handle_live(int h);
        return h != 0 && h < bump && live_map[h];
    endfunction

    function automatic rsp_t allocator_step(req_t r);
        rsp_t res;
        int   h;
        int   got;
        h = int'(r.handle_in);
        got = 0;
        res.handle_out = r.handle_in;
        res.status     = ST_BAD;
        case (r.cmd)
            CMD_ALLOC:
            begin
                if (stk_depth > 0)
                begin
                    stk_depth--;
                    got = int'(free_stk[stk_depth]);
                end
                else if (bump < CAPACITY)
                begin
                    got = bump;
                    bump++;
                end
                if (got != 0)
                begin
                    live_map[got] = 1'b1;
                    live_cnt++;
                    res.handle_out = got[HW-1:0];
                    res.status     = ST_OK;
                end
                else
                begin
                    res.handle_out = '0;
                    res.status     = ST_FULL;
                end
            end
            CMD_FREE:
            begin
                if (handle_live(h))
                begin
                    live_map[h] = 1'b0;
                    free_stk[stk_depth] = r.handle_in;
                    stk_depth++;
                    live_cnt--;
                    res.status = ST_OK;
                end
            end
            CMD_LOOKUP:
            begin
                if (handle_live(h))
                    res.status = ST_OK;
            end
            default:
            begin
            end
        endcase
        res.live_count = live_cnt[HW-1:0];
        return res;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Driver: present beats at the falling edge, random gaps between them
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy_seen)
            begin
                beat_out = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    burst = !burst;
                gap_left = burst ? 0 : $urandom_range(0, 3);
            end
            if (!beat_out)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (req_q.size() > 0)
                begin
                    req_bus <= req_q.pop_front();
                    beat_out = 1'b1;
                end
            end
            start <= beat_out;
        end
    end

    task automatic report_mismatch(string what, rsp_t e, rsp_t a);
        errors++;
        if (errors <= 10)
            $display({"%0t: %s: expected handle %0d status %0d live %0d, ",
                      "got handle %0d status %0d live %0d"},
                     $realtime, what, e.handle_out, e.status, e.live_count,
                     a.handle_out, a.status, a.live_count);
    endtask

    // Monitor: check results and predict accepted beats at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t exp_rsp;
        if (!rst_n)
        begin
            busy_seen <= 1'b0;
        end
        else
        begin
            busy_seen <= busy;
            if (done)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    exp_rsp = '0;
                    report_mismatch("unexpected result", exp_rsp, rsp_bus);
                end
                else
                begin
                    exp_rsp = expected_rsp_q.pop_front();
                    if (rsp_bus.handle_out !== exp_rsp.handle_out ||
                        rsp_bus.status     !== exp_rsp.status     ||
                        rsp_bus.live_count !== exp_rsp.live_count)
                        report_mismatch("result mismatch", exp_rsp, rsp_bus);
                end
            end
            if (start && !busy)
                expected_rsp_q.push_back(allocator_step(req_bus));
        end
    end

    // Keep the queue short so picks of live handles track the model closely
    task automatic send(logic [1:0] c, logic [HW-1:0] h);
        req_t it;
        it.cmd       = c;
        it.handle_in = h;
        while (req_q.size() >= 2)
        begin
            @(posedge clk);
            #2;
        end
        req_q.push_back(it);
    endtask

    task automatic drain();
        while (req_q.size() > 0 || start || expected_rsp_q.size() > 0)
        begin
            @(posedge clk);
            #2;
        end
    endtask

    function automatic logic [HW-1:0] pick_live();
        int h;
        h = 1;
        for (int k = 0; k < 8; k++)
        begin
            h = $urandom_range(1, bump > 1 ? bump - 1 : 1);
            if (live_map[h])
                break;
        end
        return h[HW-1:0];
    endfunction

    task automatic random_beat(int alloc_pct);
        int            r;
        logic [HW-1:0] h;
        r = $urandom_range(0, 99);
        h = HW'($urandom_range(0, CAPACITY - 1));
        if (r < alloc_pct)
            send(CMD_ALLOC, h);
        else if (r < alloc_pct + 25)
            send(CMD_FREE, pick_live());
        else if (r < alloc_pct + 35)
            send(CMD_LOOKUP, pick_live());
        else if (r < alloc_pct + 45)
            send(CMD_FREE, ($urandom_range(0, 7) == 0) ? '0 : h);
        else if (r < alloc_pct + 55)
            send(CMD_LOOKUP, ($urandom_range(0, 7) == 0) ? '0 : h);
        else
            send(CMD_UNUSED, h);
    endtask

    initial
    begin
        int fill;
        rst_n   = 1'b0;
        start   = 1'b0;
        req_bus = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Null keys, out-of-range keys, double free, LIFO reuse, unused command
        send(CMD_LOOKUP, '0);
        send(CMD_FREE, '0);
        send(CMD_ALLOC, '1);
        send(CMD_ALLOC, '0);
        send(CMD_ALLOC, 10'h155);
        send(CMD_LOOKUP, 10'd2);
        send(CMD_LOOKUP, '1);
        send(CMD_FREE, '1);
        send(CMD_FREE, 10'd2);
        send(CMD_FREE, 10'd2);
        send(CMD_LOOKUP, 10'd2);
        send(CMD_FREE, 10'd3);
        send(CMD_ALLOC, 10'h2AA);
        send(CMD_ALLOC, '0);
        send(CMD_ALLOC, '0);
        send(CMD_UNUSED, '1);
        send(CMD_UNUSED, '0);
        send(CMD_LOOKUP, 10'd4);
        send(CMD_FREE, 10'd1);
        send(CMD_LOOKUP, 10'd1);
        drain();

        repeat (500) random_beat(40);

        // Hold off, then allocate past the last handle to hit store full
        drain();
        fill = CAPACITY - 1 - live_cnt + 4;
        repeat (fill) send(CMD_ALLOC, HW'($urandom_range(0, CAPACITY - 1)));

        repeat (350) random_beat(30);

        drain();
        repeat (6) @(posedge clk);
        if (errors == 0 && expected_rsp_q.size() == 0)
            $display("handle_slot_allocator_test OK");
        else
            $display("handle_slot_allocator_test NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("handle_slot_allocator_test NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/hsa_pkg.sv
sv/hsa_ram.sv
sv/hsa_issue.sv
sv/hsa_commit.sv
sv/handle_slot_allocator.sv
sv/hsa_checker.sv
test/handle_slot_allocator_test.sv
